// File: design/u2u8_pkg.sv
// Shared types, codes and the UTF-8 byte builder for the UTF-16/32 to UTF-8 encoder.
package u2u8_pkg;

    // Request kinds on the input channel's tuser
    typedef enum logic [1:0] {
        ACT_UNIT16 = 2'd0,
        ACT_UTF32  = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Result status on the output channel's tuser
    typedef enum logic [1:0] {
        ST_BYTE   = 2'd0,
        ST_STORED = 2'd1,
        ST_ILSEQ  = 2'd2
    } status_t;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned CP_W        = 21;

    localparam logic [31:0] CP_LIMIT     = 32'h0011_0000;
    localparam logic [10:0] SUR_PAIR_ADD = 11'h040;  // 0x10000 >> 10

    // One classified request waiting for the byte emitter
    typedef struct packed {
        status_t           status;
        logic [1:0]        nlast;   // byte count minus one
        logic [CP_W-1:0]   cp;
    } u2u8_entry_t;

    // Byte idx of the UTF-8 form of cp, which is nlast+1 bytes long
    function automatic logic [7:0] utf8_byte(logic [CP_W-1:0] cp, logic [1:0] nlast,
                                             logic [1:0] idx);
        logic [1:0] sel;
        logic [5:0] six;
        logic [7:0] res;
        sel = nlast - idx;
        if (idx == 2'd0) begin
            unique case (nlast)
                2'd0: res = {1'b0, cp[6:0]};
                2'd1: res = {3'b110, cp[10:6]};
                2'd2: res = {4'b1110, cp[15:12]};
                2'd3: res = {5'b11110, cp[20:18]};
                default: res = 8'h00;
            endcase
        end else begin
            unique case (sel)
                2'd0: six = cp[5:0];
                2'd1: six = cp[11:6];
                2'd2: six = cp[17:12];
                default: six = cp[5:0];
            endcase
            res = {2'b10, six};
        end
        return res;
    endfunction

endpackage

// File: design/utf16_to_utf8_encoder.sv
// Top level of the UTF-16/UTF-32 to UTF-8 encoder.
//
//  channel | dir | handshake          | tdata            | tuser       | tlast
//  s_      | in  | s_tvalid/s_tready  | [31:0] code_value| [1:0] action| -
//  m_      | out | m_tvalid/m_tready  | [7:0]  out_byte  | [1:0] status| last
//
// A request is taken each cycle while the entry queue has room; action 3 takes
// no queue slot and gives no result. The emitter sends one byte per cycle while not
// stalled; a request gives 1 to 4 bytes (its UTF-8 length) and the emitter sets the
// rate. The first byte of a request passes the entry queue and then the output
// register. Reset clears the pending surrogate, the queue and m_tvalid. Output stalls
// back up into the queue and then into s_tready; the input side never stalls the output.
module utf16_to_utf8_encoder import u2u8_pkg::*; #(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] code_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    u2u8_entry_t push_entry, head_entry;
    logic        q_push, q_full, q_pop, q_empty;

    u2u8_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    u2u8_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head_entry),
        .empty     (q_empty)
    );

    u2u8_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_entry),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: design/u2u8_front.sv
// Front end: accepts requests, tracks the pending surrogate, classifies into queue entries.
module u2u8_front import u2u8_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] code_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic        q_full,
    output logic        q_push,
    output u2u8_entry_t q_entry
);

    logic [15:0] pending_reg, pending_next;
    logic [15:0] unit;
    logic        accept;
    logic        pend, p_hi, p_lo, u_sur, u_hi, u_lo;
    logic [9:0]  hi10, lo10;
    logic [10:0] plane;
    logic [31:0] enc_val;
    u2u8_entry_t entry;

    // Classify a code point for encoding
    function automatic u2u8_entry_t classify(logic [31:0] v);
        u2u8_entry_t e;
        e.cp = v[CP_W-1:0];
        e.status = ST_BYTE;
        if (v >= CP_LIMIT || v[31:11] == 21'h0_001B) begin
            e.status = ST_ILSEQ;
            e.nlast  = 2'd0;
            e.cp     = '0;
        end else if (v[31:7] == '0) begin
            e.nlast = 2'd0;
        end else if (v[31:11] == '0) begin
            e.nlast = 2'd1;
        end else if (v[31:16] == '0) begin
            e.nlast = 2'd2;
        end else begin
            e.nlast = 2'd3;
        end
        return e;
    endfunction

    assign unit  = s_tdata[15:0];
    assign pend  = (pending_reg != 16'h0000);
    assign p_hi  = (pending_reg[15:10] == 6'b110110);
    assign p_lo  = (pending_reg[15:10] == 6'b110111);
    assign u_sur = (unit[15:11] == 5'b11011);
    assign u_hi  = (unit[15:10] == 6'b110110);
    assign u_lo  = (unit[15:10] == 6'b110111);

    // Pair combine: high and low halves in either arrival order
    assign hi10  = (p_lo && u_hi) ? unit[9:0] : pending_reg[9:0];
    assign lo10  = (p_lo && u_hi) ? pending_reg[9:0] : unit[9:0];
    assign plane = {1'b0, hi10} + SUR_PAIR_ADD;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Request decode
    always_comb begin
        pending_next = pending_reg;
        q_push       = 1'b0;
        enc_val      = {11'h000, plane, lo10};
        entry        = classify(enc_val);
        unique case (action_t'(s_tuser))
            ACT_UNIT16: begin
                q_push = accept;
                if (!u_sur) begin
                    entry = classify({16'h0000, unit});
                    if (pend) begin
                        entry = '{status: ST_ILSEQ, nlast: 2'd0, cp: '0};
                    end
                end else if (!pend) begin
                    entry = '{status: ST_STORED, nlast: 2'd0, cp: '0};
                    if (accept) begin
                        pending_next = unit;
                    end
                end else if ((p_lo && u_hi) || (p_hi && u_lo)) begin
                    if (accept) begin
                        pending_next = 16'h0000;
                    end
                end else begin
                    entry = '{status: ST_ILSEQ, nlast: 2'd0, cp: '0};
                end
            end
            ACT_UTF32: begin
                q_push = accept;
                entry  = classify(s_tdata);
            end
            ACT_FINISH: begin
                q_push = accept;
                if (pend) begin
                    entry = '{status: ST_ILSEQ, nlast: 2'd0, cp: '0};
                end else begin
                    entry = '{status: ST_BYTE, nlast: 2'd0, cp: '0};
                end
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

    assign q_entry = entry;

    // Pending surrogate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 16'h0000;
        end else begin
            pending_reg <= pending_next;
        end
    end

endmodule

// File: design/u2u8_fifo.sv
// Short entry queue between the classifier and the byte emitter.
module u2u8_fifo import u2u8_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  u2u8_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output u2u8_entry_t head,
    output logic        empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    u2u8_entry_t   mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/u2u8_back.sv
// Back end: walks each queue entry and emits its UTF-8 bytes through an output register.
module u2u8_back import u2u8_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  u2u8_entry_t head,
    input  logic        empty,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    logic [1:0] idx_reg, idx_next;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic [1:0] m_tuser_reg;
    logic       m_tlast_reg;
    logic       load, last_byte;
    logic [7:0] byte_val;

    assign load      = !empty && (!m_tvalid_reg || m_tready);
    assign last_byte = (idx_reg == head.nlast);
    assign pop       = load && last_byte;
    assign byte_val  = (head.status == ST_BYTE) ? utf8_byte(head.cp, head.nlast, idx_reg)
                                                : 8'h00;

    // Byte index within the current entry
    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = last_byte ? 2'd0 : idx_reg + 2'd1;
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= byte_val;
            m_tuser_reg <= head.status;
            m_tlast_reg <= last_byte;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: design/u2u8_checker.sv
// Port-level checks for the encoder, bound to the top level.
module u2u8_checker import u2u8_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A waiting request holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata) && $stable(s_tuser)))
        else $error("waiting request changed");

    // Status is one of the three defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_BYTE || m_tuser == ST_STORED || m_tuser == ST_ILSEQ))
        else $error("undefined status code");

    // A non-byte status is a single zero result
    a_status_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_BYTE) |-> (m_tlast && m_tdata == 8'h00))
        else $error("status result not a lone zero result");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind utf16_to_utf8_encoder u2u8_checker u_u2u8_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
